>>> hdl/cpv_pkg.sv
// Shared types and constants for the command packet validator.
package cpv_pkg;

  // Header layout and packet framing.
  localparam int HDR_BYTES     = 6;
  localparam int HDR_IDX_W     = 3;
  localparam int HDR_ID_LEN    = 4;
  localparam int HDR_ARGS_LEN  = 5;
  localparam int MIN_PKT_BYTES = 10;
  localparam int CRC_OFFSET    = 8;

  // Byte counter width and its saturation value.
  localparam int            CNT_W   = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Value that closes the id and args fields.
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // Default packet buffer size.
  localparam int DEF_MAX_FRAME_BYTES = 1024;

  // Result status codes; the first failing check in this order wins.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_BAD_ID_TERM  = 3'd2,
    ST_BAD_ARGS_TERM = 3'd3,
    ST_LEN_MISMATCH = 3'd4
  } status_t;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

endpackage

>>> hdl/cpv_in_reg.sv
// Input register stage that holds one packet byte for the parser.
module cpv_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          beat_valid_o,
  output cpv_pkg::beat_t beat_o,
  input  logic          beat_take_i
);
  import cpv_pkg::*;

  logic  valid_r;
  beat_t beat_r;

  // The register can load when it is empty or its beat leaves this cycle.
  assign in_ready     = !valid_r || beat_take_i;
  assign beat_valid_o = valid_r;
  assign beat_o       = beat_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r.data_byte <= in_data_byte;
      beat_r.last_byte <= in_last_byte;
    end
  end

endmodule

>>> hdl/cpv_parser.sv
// Packet state, field capture, checks and the result register.
module cpv_parser #(
  parameter int MAX_FRAME_BYTES = cpv_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           beat_valid_i,
  input  cpv_pkg::beat_t beat_i,
  output logic           beat_take_o,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_status,
  output logic [7:0]     out_origin_node,
  output logic [7:0]     out_destination_node,
  output logic [7:0]     out_echo_tag,
  output logic [7:0]     out_packet_type,
  output logic [7:0]     out_id_length,
  output logic [7:0]     out_args_length,
  output logic [15:0]    out_crc_value
);
  import cpv_pkg::*;

  localparam logic [16:0] MAX_BYTES = 17'(MAX_FRAME_BYTES);

  // Packet state.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       hdr_r [HDR_BYTES];
  logic [7:0]       hdr_nxt [HDR_BYTES];
  logic             id_ok_r, id_ok_nxt;
  logic             args_ok_r, args_ok_nxt;
  logic [15:0]      crc_r, crc_nxt;

  // Result register.
  logic             out_valid_r;
  status_t          status_r;
  logic [7:0]       res_hdr_r [HDR_BYTES];
  logic [15:0]      res_crc_r;

  logic             fire;
  logic             in_body;
  logic [CNT_W-1:0] id_pos;
  logic [CNT_W-1:0] args_pos;
  logic [CNT_W-1:0] crc_pos;
  logic [CNT_W-1:0] need;
  logic [CNT_W-1:0] cnt_inc;
  status_t          status_nxt;

  // A last beat waits while the result register is still full.
  assign beat_take_o = beat_valid_i && (!beat_i.last_byte || !out_valid_r || out_ready);
  assign fire        = beat_take_o;

  // Field positions from the captured lengths.
  assign id_pos   = CNT_W'(HDR_BYTES) + CNT_W'(hdr_r[HDR_ID_LEN]);
  assign args_pos = id_pos + CNT_W'(1) + CNT_W'(hdr_r[HDR_ARGS_LEN]);
  assign crc_pos  = CNT_W'(hdr_r[HDR_ID_LEN]) + CNT_W'(hdr_r[HDR_ARGS_LEN])
                  + CNT_W'(CRC_OFFSET);
  assign in_body  = (cnt_r >= CNT_W'(HDR_BYTES)) && (17'(cnt_r) < MAX_BYTES);
  assign cnt_inc  = (cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  // Capture and terminator checks for the current byte.
  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_nxt[i] = hdr_r[i];
      if (cnt_r == CNT_W'(i)) begin
        hdr_nxt[i] = beat_i.data_byte;
      end
    end
    id_ok_nxt   = id_ok_r;
    args_ok_nxt = args_ok_r;
    crc_nxt     = crc_r;
    // A nonzero args length means its terminator is still owed.
    if (cnt_r == CNT_W'(HDR_ARGS_LEN) && beat_i.data_byte != 8'h00) begin
      args_ok_nxt = 1'b0;
    end
    if (in_body) begin
      if (cnt_r == id_pos) begin
        id_ok_nxt = (beat_i.data_byte == TERM_BYTE);
      end
      if (hdr_r[HDR_ARGS_LEN] != 8'h00 && cnt_r == args_pos) begin
        args_ok_nxt = (beat_i.data_byte == TERM_BYTE);
      end
      if (cnt_r == crc_pos) begin
        crc_nxt[7:0] = beat_i.data_byte;
      end
      if (cnt_r == crc_pos + CNT_W'(1)) begin
        crc_nxt[15:8] = beat_i.data_byte;
      end
    end
    cnt_nxt = cnt_inc;
  end

  // Status of the packet as it stands after this byte.
  assign need = CNT_W'(hdr_nxt[HDR_ID_LEN]) + CNT_W'(hdr_nxt[HDR_ARGS_LEN])
              + CNT_W'(MIN_PKT_BYTES);

  always_comb begin
    priority if (cnt_nxt < CNT_W'(MIN_PKT_BYTES)) begin
      status_nxt = ST_SHORT;
    end else if (!id_ok_nxt) begin
      status_nxt = ST_BAD_ID_TERM;
    end else if (!args_ok_nxt) begin
      status_nxt = ST_BAD_ARGS_TERM;
    end else if (cnt_nxt != need) begin
      status_nxt = ST_LEN_MISMATCH;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // Packet state update; the last byte clears it for the next packet.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && beat_i.last_byte)) begin
      cnt_r     <= '0;
      id_ok_r   <= 1'b0;
      args_ok_r <= 1'b1;
      crc_r     <= '0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (fire) begin
      cnt_r     <= cnt_nxt;
      id_ok_r   <= id_ok_nxt;
      args_ok_r <= args_ok_nxt;
      crc_r     <= crc_nxt;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && beat_i.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire && beat_i.last_byte) begin
      status_r  <= status_nxt;
      res_crc_r <= crc_nxt;
      for (int i = 0; i < HDR_BYTES; i++) begin
        res_hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_origin_node      = res_hdr_r[0];
  assign out_destination_node = res_hdr_r[1];
  assign out_echo_tag         = res_hdr_r[2];
  assign out_packet_type      = res_hdr_r[3];
  assign out_id_length        = res_hdr_r[HDR_ID_LEN];
  assign out_args_length      = res_hdr_r[HDR_ARGS_LEN];
  assign out_crc_value        = res_crc_r;

endmodule

>>> hdl/command_packet_validator.sv
// Top level of the command packet validator.
//
// Takes one packet byte per cycle while in_ready is high, a rate set by the byte
// counter and the combinational terminator and CRC position compares, the final
// byte flagged by in_last_byte, and gives one result beat per packet: a status
// plus the six header bytes and the little-endian CRC from the trailer. The CRC
// is captured, not checked. A byte passes through an input register and then
// the parser, whose result register takes the result when the last byte leaves
// the input register; that byte waits there while the result register is full.
// The input side keeps taking bytes while a result waits; only a further last
// byte waits for the result register to empty. Bytes at or past MAX_FRAME_BYTES
// are counted but not captured.
module command_packet_validator #(
  parameter int MAX_FRAME_BYTES = cpv_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_origin_node,
  output logic [7:0]  out_destination_node,
  output logic [7:0]  out_echo_tag,
  output logic [7:0]  out_packet_type,
  output logic [7:0]  out_id_length,
  output logic [7:0]  out_args_length,
  output logic [15:0] out_crc_value
);
  import cpv_pkg::*;

  logic  beat_valid;
  beat_t beat;
  logic  beat_take;

  // Input register.
  cpv_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .beat_take_i  (beat_take)
  );

  // Parser and result register.
  cpv_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk                  (clk),
    .rst_n                (rst_n),
    .beat_valid_i         (beat_valid),
    .beat_i               (beat),
    .beat_take_o          (beat_take),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_origin_node      (out_origin_node),
    .out_destination_node (out_destination_node),
    .out_echo_tag         (out_echo_tag),
    .out_packet_type      (out_packet_type),
    .out_id_length        (out_id_length),
    .out_args_length      (out_args_length),
    .out_crc_value        (out_crc_value)
  );

endmodule

>>> tb/sv/command_packet_validator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the command packet validator.
module command_packet_validator_test;
  import cpv_pkg::*;

  localparam int FRAME_BYTES  = DEF_MAX_FRAME_BYTES;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_BYTES  = 420;
  localparam int RANDOM_BYTES = 1250;
  localparam int RUN_LIMIT_NS = 2000000;

  // One result beat as seen on the output ports.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  origin;
    logic [7:0]  destination;
    logic [7:0]  echo;
    logic [7:0]  ptype;
    logic [7:0]  id_len;
    logic [7:0]  arg_len;
    logic [15:0] crc;
  } verdict_t;

  // Ways a random packet is damaged before it is sent.
  typedef enum int {
    FLAW_NONE, FLAW_ID_TERM, FLAW_ARGS_TERM, FLAW_EXTRA, FLAW_DROP, FLAW_TRUNC, FLAW_NOISE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_origin_node;
  logic [7:0]  out_destination_node;
  logic [7:0]  out_echo_tag;
  logic [7:0]  out_packet_type;
  logic [7:0]  out_id_length;
  logic [7:0]  out_args_length;
  logic [15:0] out_crc_value;

  int         tx_idle_pct = 30;
  int         rx_idle_pct = 79;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         bytes_sent = 0;
  logic [7:0] pkt_bytes[$];

  // Tracks the packet in flight and the verdicts still owed by the block.
  class packet_verdict_board;
    logic [CNT_W-1:0] seen;
    logic [7:0]       hdr[HDR_BYTES];
    bit               id_term_good;
    bit               args_term_good;
    logic [15:0]      crc;
    verdict_t         verdicts_due[$];
    int               mismatches;
    int               verdicts_seen;

    function new();
      mismatches = 0;
      verdicts_seen = 0;
      restart();
    endfunction

    function void restart();
      seen = '0;
      foreach (hdr[i]) hdr[i] = 8'h00;
      id_term_good = 1'b0;
      args_term_good = 1'b1;
      crc = 16'h0000;
    endfunction

    // Advances the packet state by one accepted beat.
    function void note_byte(logic [7:0] b, logic last);
      int unsigned pos, id_len, arg_len, id_pos, args_pos, crc_pos, need;
      verdict_t v;
      pos = 32'(seen);
      if (pos < HDR_BYTES) begin
        hdr[pos] = b;
        if (pos == HDR_ARGS_LEN && b != TERM_BYTE) args_term_good = 1'b0;
      end else if (pos < FRAME_BYTES) begin
        id_len = 32'(hdr[HDR_ID_LEN]);
        arg_len = 32'(hdr[HDR_ARGS_LEN]);
        id_pos = HDR_BYTES + id_len;
        args_pos = id_pos + 1 + arg_len;
        crc_pos = id_len + arg_len + CRC_OFFSET;
        if (pos == id_pos) id_term_good = (b == TERM_BYTE);
        if (arg_len != 0 && pos == args_pos) args_term_good = (b == TERM_BYTE);
        if (pos == crc_pos) crc[7:0] = b;
        if (pos == crc_pos + 1) crc[15:8] = b;
      end
      if (seen != CNT_MAX) seen++;
      if (!last) return;

      // The first failing check decides the status.
      need = 32'(hdr[HDR_ID_LEN]) + 32'(hdr[HDR_ARGS_LEN]) + MIN_PKT_BYTES;
      if (seen < MIN_PKT_BYTES) v.status = ST_SHORT;
      else if (!id_term_good) v.status = ST_BAD_ID_TERM;
      else if (!args_term_good) v.status = ST_BAD_ARGS_TERM;
      else if (seen != need) v.status = ST_LEN_MISMATCH;
      else v.status = ST_OK;
      v.origin = hdr[0];
      v.destination = hdr[1];
      v.echo = hdr[2];
      v.ptype = hdr[3];
      v.id_len = hdr[HDR_ID_LEN];
      v.arg_len = hdr[HDR_ARGS_LEN];
      v.crc = crc;
      verdicts_due.push_back(v);
      restart();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one result beat with the oldest verdict owed.
    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: status expected no result, actual %0h", $time, got.status);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      verdicts_seen++;
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("origin_node", 16'(want.origin), 16'(got.origin));
      compare_field("destination_node", 16'(want.destination), 16'(got.destination));
      compare_field("echo_tag", 16'(want.echo), 16'(got.echo));
      compare_field("packet_type", 16'(want.ptype), 16'(got.ptype));
      compare_field("id_length", 16'(want.id_len), 16'(got.id_len));
      compare_field("args_length", 16'(want.arg_len), 16'(got.arg_len));
      compare_field("crc_value", want.crc, got.crc);
    endfunction
  endclass

  packet_verdict_board board;

  command_packet_validator i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_origin_node      (out_origin_node),
    .out_destination_node (out_destination_node),
    .out_echo_tag         (out_echo_tag),
    .out_packet_type      (out_packet_type),
    .out_id_length        (out_id_length),
    .out_args_length      (out_args_length),
    .out_crc_value        (out_crc_value)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or a long counted hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_verdict({out_status, out_origin_node, out_destination_node, out_echo_tag,
                           out_packet_type, out_id_length, out_args_length, out_crc_value});
    end
  end

  // Runaway guard.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // Sends one beat, idling at random first; starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // Sender pauses until every owed verdict has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.verdicts_due.size() != 0) @(negedge clk);
  endtask

  // Builds a well-formed packet with random header, contents and CRC.
  function void build_packet(int id_len, int arg_len);
    pkt_bytes.delete();
    repeat (4) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(8'(id_len));
    pkt_bytes.push_back(8'(arg_len));
    repeat (id_len) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(TERM_BYTE);
    repeat (arg_len) pkt_bytes.push_back(8'($urandom_range(255)));
    pkt_bytes.push_back(TERM_BYTE);
    repeat (2) pkt_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function void truncate_packet(int keep);
    while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
  endfunction

  // Mostly well-formed packets, the rest damaged in one way or pure noise.
  task automatic random_packet();
    int    id_len, arg_len;
    flaw_t flaw;
    id_len = ($urandom_range(31) == 0) ? $urandom_range(255) : $urandom_range(12);
    arg_len = ($urandom_range(31) == 0) ? $urandom_range(255) : $urandom_range(12);
    build_packet(id_len, arg_len);
    flaw = ($urandom_range(99) < 60) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
    case (flaw)
      FLAW_ID_TERM: pkt_bytes[HDR_BYTES + id_len] = 8'($urandom_range(1, 255));
      FLAW_ARGS_TERM: pkt_bytes[HDR_BYTES + id_len + 1 + arg_len] = 8'($urandom_range(1, 255));
      FLAW_EXTRA: repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(255)));
      FLAW_DROP: void'(pkt_bytes.pop_back());
      FLAW_TRUNC: truncate_packet($urandom_range(1, pkt_bytes.size()));
      FLAW_NOISE: begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 30)) pkt_bytes.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    send_packet();
  endtask

  // Hand-picked packets for the extremes and each special case.
  task automatic directed_packets();
    // First four header bytes and CRC all ones, no id or args.
    build_packet(0, 0);
    for (int i = 0; i < 4; i++) pkt_bytes[i] = 8'hFF;
    pkt_bytes[8] = 8'hFF;
    pkt_bytes[9] = 8'hFF;
    send_packet();
    // Header bytes and CRC all zero.
    build_packet(0, 0);
    for (int i = 0; i < 4; i++) pkt_bytes[i] = 8'h00;
    pkt_bytes[8] = 8'h00;
    pkt_bytes[9] = 8'h00;
    send_packet();
    build_packet(3, 4);
    send_packet();
    // A lone byte: missing header and CRC bytes read as zero.
    pkt_bytes.delete();
    pkt_bytes.push_back(8'hA5);
    send_packet();
    // Nine bytes is one short of the minimum.
    build_packet(0, 0);
    truncate_packet(9);
    send_packet();
    // Bad id terminator, then bad args terminator.
    build_packet(2, 3);
    pkt_bytes[HDR_BYTES + 2] = 8'h01;
    send_packet();
    build_packet(2, 3);
    pkt_bytes[HDR_BYTES + 2 + 1 + 3] = 8'h80;
    send_packet();
    // Empty args: junk in the args terminator slot is not checked.
    build_packet(4, 0);
    pkt_bytes[HDR_BYTES + 4 + 1] = 8'h5A;
    send_packet();
    // One byte too many, then one too few.
    build_packet(1, 1);
    pkt_bytes.push_back(8'($urandom_range(255)));
    send_packet();
    build_packet(5, 2);
    void'(pkt_bytes.pop_back());
    send_packet();
    // Terminators placed beyond the end of the packet.
    build_packet(200, 0);
    truncate_packet(20);
    send_packet();
    build_packet(2, 200);
    truncate_packet(30);
    send_packet();
    // Longest well-formed packet.
    build_packet(255, 255);
    send_packet();
    // Runs past the buffer size and on until the byte counter saturates.
    build_packet(255, 255);
    while (pkt_bytes.size() < int'(CNT_MAX) + 53) pkt_bytes.push_back(8'($urandom_range(255)));
    send_packet();
    // A clean packet right after, to see the state was cleared.
    build_packet(1, 0);
    send_packet();
  endtask

  // Holds the receiver off while short packets keep coming, so the block backs up.
  task automatic squeeze_output();
    hold_req = 1'b1;
    repeat (12) begin
      if ($urandom_range(1)) begin
        build_packet(0, 0);
      end else begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(255)));
      end
      send_packet();
    end
    drain();
  endtask

  // Main sequence.
  initial begin
    int rand_start;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_packets();
    drain();
    rand_start = bytes_sent;

    // Sender idles lightly, receiver heavily.
    while (bytes_sent - rand_start < PHASE_BYTES) random_packet();
    drain();

    // Sender idles heavily, receiver lightly.
    tx_idle_pct = 79;
    rx_idle_pct = 30;
    while (bytes_sent - rand_start < 2 * PHASE_BYTES) random_packet();
    drain();

    // No idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    squeeze_output();
    while (bytes_sent - rand_start < RANDOM_BYTES) random_packet();
    in_valid <= 1'b0;

    while (board.verdicts_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.verdicts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
